// ===== rtl/core/iirdf1_pkg.sv =====
// shared constants, codes and controller-to-datapath command type of the iir filter
`default_nettype none

package iirdf1_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned ORD_W    = 5;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;

  // stream packing
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 16;

  // tap counter field wide enough for the largest supported order
  localparam int unsigned TAP_W = 6;

  // parameter defaults
  localparam int unsigned ORDER_MAX_DEF      = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 20;

  // request kinds on s_axis_tuser
  localparam logic [KIND_W-1:0] REQ_SAMPLE   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_WR_FF    = 2'd1;
  localparam logic [KIND_W-1:0] REQ_WR_FB    = 2'd2;
  localparam logic [KIND_W-1:0] REQ_CLR_HIST = 2'd3;

  // configuration register indexes
  localparam logic REG_FF_ORDER = 1'b0;
  localparam logic REG_FB_ORDER = 1'b1;

  typedef struct packed {
    logic             start;     // sample accepted: push x, clear accumulator
    logic             wr_ff;     // write numerator coefficient
    logic             wr_fb;     // write denominator coefficient
    logic             clr_hist;  // zero both histories
    logic             issue;     // start one multiply-accumulate tap
    logic             fb;        // tap belongs to the feedback sum
    logic [TAP_W-1:0] tap;       // tap index
    logic             finish;    // round, load output, shift output history
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/iir_direct_form_one_filter.sv =====
// direct form i iir filter: order registers, controller and mac datapath
// sample item: after transfer the taps are issued, the pipeline drains and the result
//   is loaded once the output is free; the next item is taken once the result is loaded
// one shared multiplier handles one tap per cycle, nb + 1 + na taps per sample
// coefficient writes and history clears give no result
// rst_ni clears orders, histories and coefficients (coefficients read zero until written)
`default_nettype none

module iir_direct_form_one_filter #(
  parameter int unsigned ORDER_MAX      = iirdf1_pkg::ORDER_MAX_DEF,
  parameter int unsigned COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic [iirdf1_pkg::ORD_W-1:0]         cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // sample_in [15:0], coef_index [20:16], coef_value [44:21], zero [47:45]
  input  wire logic [iirdf1_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // req_type [1:0]
  input  wire logic [iirdf1_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // filtered_sample [15:0]
  output logic [iirdf1_pkg::M_DATA_W-1:0]           m_axis_tdata,
  // saturated [0]
  output logic                                      m_axis_tuser
);

  iirdf1_pkg::cmd_t                       cmd;
  logic                                   out_free;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y;

  iirdf1_ctrl #(
    .ORDER_MAX (ORDER_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .out_free_i  (out_free),
    .cmd_o       (cmd)
  );

  iirdf1_dpath #(
    .ORDER_MAX      (ORDER_MAX),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sample_in_i       (s_axis_tdata[15:0]),
    .coef_index_i      (s_axis_tdata[20:16]),
    .coef_value_i      (s_axis_tdata[44:21]),
    .out_free_o        (out_free),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .filtered_sample_o (y),
    .saturated_o       (m_axis_tuser)
  );

  assign m_axis_tdata = y;

endmodule

`default_nettype wire

// ===== rtl/core/iirdf1_ctrl.sv =====
// sequencing state machine and order registers of the iir filter
`default_nettype none

module iirdf1_ctrl #(
  parameter int unsigned ORDER_MAX = iirdf1_pkg::ORDER_MAX_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [iirdf1_pkg::ORD_W-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [iirdf1_pkg::KIND_W-1:0] in_kind_i,
  input  wire logic                         out_free_i,
  output iirdf1_pkg::cmd_t                  cmd_o
);

  localparam int unsigned CI_W = $clog2(ORDER_MAX + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FF    = 3'd1;
  localparam logic [2:0] ST_FB    = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [CI_W-1:0]                tap_q, tap_d;
  logic                           drain_q, drain_d;
  logic [iirdf1_pkg::ORD_W-1:0]   ff_ord_q, fb_ord_q;
  logic [CI_W-1:0]                nb, na;
  logic                           accept;

  // orders above the supported maximum saturate
  always_comb begin
    if ({1'b0, ff_ord_q} > 6'(ORDER_MAX)) nb = CI_W'(ORDER_MAX);
    else nb = CI_W'({1'b0, ff_ord_q});
    if ({1'b0, fb_ord_q} > 6'(ORDER_MAX)) na = CI_W'(ORDER_MAX);
    else na = CI_W'({1'b0, fb_ord_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_ord_q <= '0;
      fb_ord_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iirdf1_pkg::REG_FF_ORDER: ff_ord_q <= cfg_wdata_i;
        iirdf1_pkg::REG_FB_ORDER: fb_ord_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    drain_d = drain_q;
    cmd_o   = '0;
    cmd_o.tap = iirdf1_pkg::TAP_W'(tap_q);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            iirdf1_pkg::REQ_SAMPLE: begin
              cmd_o.start = 1'b1;
              tap_d       = '0;
              state_d     = ST_FF;
            end
            iirdf1_pkg::REQ_WR_FF:    cmd_o.wr_ff    = 1'b1;
            iirdf1_pkg::REQ_WR_FB:    cmd_o.wr_fb    = 1'b1;
            iirdf1_pkg::REQ_CLR_HIST: cmd_o.clr_hist = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FF: begin
        cmd_o.issue = 1'b1;
        if (tap_q == nb) begin
          if (na == '0) begin
            drain_d = 1'b0;
            state_d = ST_DRAIN;
          end else begin
            tap_d   = CI_W'(1);
            state_d = ST_FB;
          end
        end else begin
          tap_d = tap_q + CI_W'(1);
        end
      end
      ST_FB: begin
        cmd_o.issue = 1'b1;
        cmd_o.fb    = 1'b1;
        if (tap_q == na) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + CI_W'(1);
        end
      end
      ST_DRAIN: begin
        // read and multiply stages empty into the accumulator
        drain_d = 1'b1;
        if (drain_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      drain_q <= drain_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/iirdf1_dpath.sv =====
// coefficient memories, histories, shared multiply-accumulate and output stage
`default_nettype none

module iirdf1_dpath #(
  parameter int unsigned ORDER_MAX      = iirdf1_pkg::ORDER_MAX_DEF,
  parameter int unsigned COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire iirdf1_pkg::cmd_t                      cmd_i,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic [iirdf1_pkg::IDX_W-1:0]          coef_index_i,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]  coef_value_i,
  output logic                                       out_free_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]     filtered_sample_o,
  output logic                                       saturated_o
);

  localparam int unsigned CI_W   = $clog2(ORDER_MAX + 1);
  localparam int unsigned HI_W   = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
  localparam int unsigned ACC_W0 = iirdf1_pkg::PROD_W + $clog2(2 * ORDER_MAX + 1) + 1;
  localparam int unsigned ACC_W  = (ACC_W0 > COEF_FRAC_BITS + 17) ? ACC_W0
                                                                 : COEF_FRAC_BITS + 17;
  localparam int unsigned SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0]  Y_MAX = SH_W'(32767);
  localparam logic signed [SH_W-1:0]  Y_MIN = SH_W'(-32768);

  // coefficient stores, zero until written
  logic signed [iirdf1_pkg::COEF_W-1:0] ff_mem [0:ORDER_MAX];
  logic signed [iirdf1_pkg::COEF_W-1:0] fb_mem [0:ORDER_MAX];
  logic [ORDER_MAX:0]                   ff_vld_q, fb_vld_q;

  // x line holds x[n] .. x[n-ORDER_MAX] once the sample is pushed
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] xline_q [0:ORDER_MAX];
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] yline_q [0:ORDER_MAX-1];

  logic [5:0]      widx6;
  logic            widx_ok;
  logic [CI_W-1:0] widx, tap;
  logic [HI_W-1:0] yidx;

  logic signed [iirdf1_pkg::COEF_W-1:0]   ff_rd_q, fb_rd_q, coef;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] hist_q;
  logic                                   rd_vld_q, rd_fb_q, rd_cvld_q;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_q;
  logic                                   p_vld_q, p_fb_q;
  logic signed [ACC_W-1:0]                acc_q, rnd;
  logic signed [SH_W-1:0]                 sh;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_sat;
  logic                                   y_clip;
  logic                                   out_vld_q;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_y_q;
  logic                                   out_sat_q;

  assign widx6   = {1'b0, coef_index_i};
  assign widx_ok = (widx6 <= 6'(ORDER_MAX));
  assign widx    = widx6[CI_W-1:0];
  assign tap     = cmd_i.tap[CI_W-1:0];
  assign yidx    = HI_W'(tap - CI_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_ff && widx_ok) ff_mem[widx] <= coef_value_i;
    if (cmd_i.wr_fb && widx_ok) fb_mem[widx] <= coef_value_i;
    ff_rd_q <= ff_mem[tap];
    fb_rd_q <= fb_mem[tap];
    hist_q  <= cmd_i.fb ? yline_q[yidx] : xline_q[tap];
    prod_q  <= coef * hist_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_vld_q <= '0;
      fb_vld_q <= '0;
    end else begin
      if (cmd_i.wr_ff && widx_ok) ff_vld_q[widx] <= 1'b1;
      if (cmd_i.wr_fb && widx_ok) fb_vld_q[widx] <= 1'b1;
    end
  end

  // histories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ORDER_MAX; i++) xline_q[i] <= '0;
      for (int i = 0; i < ORDER_MAX; i++) yline_q[i] <= '0;
    end else if (cmd_i.clr_hist) begin
      for (int i = 0; i <= ORDER_MAX; i++) xline_q[i] <= '0;
      for (int i = 0; i < ORDER_MAX; i++) yline_q[i] <= '0;
    end else begin
      if (cmd_i.start) begin
        xline_q[0] <= sample_in_i;
        for (int i = 1; i <= ORDER_MAX; i++) xline_q[i] <= xline_q[i-1];
      end
      if (cmd_i.finish) begin
        yline_q[0] <= y_sat;
        for (int i = 1; i < ORDER_MAX; i++) yline_q[i] <= yline_q[i-1];
      end
    end
  end

  // read, multiply, accumulate pipeline
  always_comb begin
    if (!rd_cvld_q) coef = '0;
    else coef = rd_fb_q ? fb_rd_q : ff_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_fb_q   <= 1'b0;
      rd_cvld_q <= 1'b0;
      p_vld_q   <= 1'b0;
      p_fb_q    <= 1'b0;
      acc_q     <= '0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      rd_fb_q   <= cmd_i.fb;
      rd_cvld_q <= cmd_i.fb ? fb_vld_q[tap] : ff_vld_q[tap];
      p_vld_q   <= rd_vld_q;
      p_fb_q    <= rd_fb_q;
      if (cmd_i.start) acc_q <= '0;
      else if (p_vld_q) begin
        if (p_fb_q) acc_q <= acc_q - ACC_W'(prod_q);
        else acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // round half up, then clip to 16 bits
  assign rnd = acc_q + HALF;
  assign sh  = rnd[ACC_W-1:COEF_FRAC_BITS];

  always_comb begin
    if (sh > Y_MAX) begin
      y_sat  = 16'sh7fff;
      y_clip = 1'b1;
    end else if (sh < Y_MIN) begin
      y_sat  = -16'sh8000;
      y_clip = 1'b1;
    end else begin
      y_sat  = sh[iirdf1_pkg::SAMPLE_W-1:0];
      y_clip = 1'b0;
    end
  end

  // output register parts the result from the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_y_q   <= y_sat;
      out_sat_q <= y_clip;
    end
  end

  assign out_free_o        = !out_vld_q || out_ready_i;
  assign out_valid_o       = out_vld_q;
  assign filtered_sample_o = out_y_q;
  assign saturated_o       = out_sat_q;

endmodule

`default_nettype wire
